>>> rtl/core/atachs_pkg.sv
// Shared constants and types of the ATA CHS task-file builder.
package atachs_pkg;

    localparam int unsigned DEFAULT_SECTORS_DEF = 2;

    localparam int unsigned QUOT_W = 32;
    localparam int unsigned CNT_W  = 9;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ABSENT   = 2'd1;
    localparam logic [1:0] ST_PARTBAD  = 2'd2;

    localparam logic [7:0] OP_READ   = 8'h20;
    localparam logic [7:0] OP_READM  = 8'hC4;
    localparam logic [7:0] OP_WRITE  = 8'h30;
    localparam logic [7:0] OP_WRITEM = 8'hC5;

    localparam logic [7:0] DH_BASE = 8'hA0;

    localparam logic [2:0] REG_ENABLED   = 3'd0;
    localparam logic [2:0] REG_SPT       = 3'd1;
    localparam logic [2:0] REG_HEADS     = 3'd2;
    localparam logic [2:0] REG_PART_EN   = 3'd3;
    localparam logic [2:0] REG_PART_BASE = 3'd4;
    localparam logic [2:0] REG_PART_SIZE = 3'd5;
    localparam logic [2:0] REG_MULTI     = 3'd6;

    // Control and request data that ride alongside the dividers.
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [8:0] count;
        logic       dsel;
        logic [7:0] cmd;
        logic [7:0] chunk;
    } t_req;

endpackage

>>> rtl/core/ata_request_chs_task_file.sv
// ATA CHS task-file builder: request check, LBA to CHS split and burst plan.
// Pipeline: a result strobes after its start transfer passes the entry stage,
// 32 one-bit steps of the sector divider, one hand-over stage, 32 one-bit
// steps of the head divider and the output register.
// Throughput: one request per cycle; busy never rises. Reset clears the
// configuration to its defaults and empties the pipeline; the receiver cannot stall.
module ata_request_chs_task_file
    import atachs_pkg::*;
#(
    parameter int unsigned DEFAULT_SECTORS = DEFAULT_SECTORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic        i_drive_select,
    input  logic [31:0] i_block_number,
    input  logic [8:0]  i_sector_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_count_byte,
    output logic [7:0]  o_sector_number,
    output logic [15:0] o_cylinder_number,
    output logic [7:0]  o_drive_head,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_chunk_sectors,
    output logic [8:0]  o_chunk_count,
    output logic [7:0]  o_last_chunk_sectors
);

    localparam int unsigned NA = QUOT_W;
    localparam int unsigned NB = QUOT_W;

    // Configuration registers
    logic        r_enabled;
    logic [7:0]  r_spt;
    logic [4:0]  r_heads;
    logic        r_part_en;
    logic [31:0] r_part_base;
    logic [31:0] r_part_size;
    logic [7:0]  r_multi;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_spt       <= 8'd17;
            r_heads     <= 5'd0;
            r_part_en   <= 1'b0;
            r_part_base <= 32'd0;
            r_part_size <= 32'd0;
            r_multi     <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLED:   r_enabled   <= i_cfg_data[0];
                REG_SPT:       r_spt       <= i_cfg_data[7:0];
                REG_HEADS:     r_heads     <= i_cfg_data[4:0];
                REG_PART_EN:   r_part_en   <= i_cfg_data[0];
                REG_PART_BASE: r_part_base <= i_cfg_data;
                REG_PART_SIZE: r_part_size <= i_cfg_data;
                REG_MULTI:     r_multi     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Entry stage: checks, count default and saturation, absolute sector, opcode
    t_req        n_entry;
    logic [8:0]  n_count;

    always_comb begin
        n_count = (i_sector_count == 9'd0) ? 9'(DEFAULT_SECTORS) :
                  (i_sector_count > 9'd256) ? 9'd256 : i_sector_count;
        n_entry.valid  = start;
        if (!r_enabled || r_heads == 5'd0 || r_spt == 8'd0) begin
            n_entry.status = ST_ABSENT;
        end else if (!r_part_en || r_part_size < i_block_number) begin
            n_entry.status = ST_PARTBAD;
        end else begin
            n_entry.status = ST_OK;
        end
        n_entry.count = n_count;
        n_entry.dsel  = i_drive_select;
        if (!i_action) begin
            n_entry.cmd = (r_multi != 8'd0) ? OP_READM : OP_READ;
        end else begin
            n_entry.cmd = (r_multi != 8'd0) ? OP_WRITEM : OP_WRITE;
        end
        n_entry.chunk = (r_multi != 8'd0) ? r_multi : 8'd1;
    end

    // Stage A: absolute sector / sectors per track, count / chunk alongside
    t_req        r_pa   [0:NA];
    logic [7:0]  r_a_rem[0:NA];
    logic [31:0] r_a_dq [0:NA];
    logic [7:0]  r_c_rem[0:NA];
    logic [8:0]  r_c_dq [0:NA];
    logic [7:0]  n_a_rem[1:NA];
    logic [31:0] n_a_dq [1:NA];
    logic [7:0]  n_c_rem[1:NA];
    logic [8:0]  n_c_dq [1:NA];

    logic [8:0]  a_t;
    logic        a_ge;
    logic [8:0]  c_t;
    logic        c_ge;

    always_comb begin
        a_t  = '0;
        a_ge = 1'b0;
        c_t  = '0;
        c_ge = 1'b0;
        for (int k = 1; k <= NA; k++) begin
            a_t  = {r_a_rem[k-1], r_a_dq[k-1][31]};
            a_ge = (a_t >= {1'b0, r_spt});
            n_a_rem[k] = a_ge ? 8'(a_t - {1'b0, r_spt}) : a_t[7:0];
            n_a_dq[k]  = {r_a_dq[k-1][30:0], a_ge};
            if (k <= CNT_W) begin
                c_t  = {r_c_rem[k-1], r_c_dq[k-1][8]};
                c_ge = (c_t >= {1'b0, r_pa[k-1].chunk});
                n_c_rem[k] = c_ge ? 8'(c_t - {1'b0, r_pa[k-1].chunk}) : c_t[7:0];
                n_c_dq[k]  = {r_c_dq[k-1][7:0], c_ge};
            end else begin
                n_c_rem[k] = r_c_rem[k-1];
                n_c_dq[k]  = r_c_dq[k-1];
            end
        end
    end

    // Stage B: track / heads
    t_req        r_pb    [0:NB];
    logic [4:0]  r_b_rem [0:NB];
    logic [31:0] r_b_dq  [0:NB];
    logic [7:0]  r_b_sec [0:NB];
    logic [8:0]  r_b_nch [0:NB];
    logic [7:0]  r_b_last[0:NB];
    logic [4:0]  n_b_rem [1:NB];
    logic [31:0] n_b_dq  [1:NB];

    logic [5:0]  b_t;
    logic        b_ge;

    always_comb begin
        b_t  = '0;
        b_ge = 1'b0;
        for (int k = 1; k <= NB; k++) begin
            b_t  = {r_b_rem[k-1], r_b_dq[k-1][31]};
            b_ge = (b_t >= {1'b0, r_heads});
            n_b_rem[k] = b_ge ? 5'(b_t - {1'b0, r_heads}) : b_t[4:0];
            n_b_dq[k]  = {r_b_dq[k-1][30:0], b_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        // Valid bits advance under reset control
        if (!i_rst_n) begin
            for (int k = 0; k <= NA; k++) r_pa[k].valid <= 1'b0;
            for (int k = 0; k <= NB; k++) r_pb[k].valid <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_pa[0].valid <= n_entry.valid;
            for (int k = 1; k <= NA; k++) r_pa[k].valid <= r_pa[k-1].valid;
            r_pb[0].valid <= r_pa[NA].valid;
            for (int k = 1; k <= NB; k++) r_pb[k].valid <= r_pb[k-1].valid;
            o_result_valid <= r_pb[NB].valid;
        end

        // Payload advances every cycle
        r_pa[0].status <= n_entry.status;
        r_pa[0].count  <= n_entry.count;
        r_pa[0].dsel   <= n_entry.dsel;
        r_pa[0].cmd    <= n_entry.cmd;
        r_pa[0].chunk  <= n_entry.chunk;
        r_a_rem[0]     <= 8'd0;
        r_a_dq[0]      <= i_block_number + r_part_base;
        r_c_rem[0]     <= 8'd0;
        r_c_dq[0]      <= n_count;
        for (int k = 1; k <= NA; k++) begin
            r_pa[k].status <= r_pa[k-1].status;
            r_pa[k].count  <= r_pa[k-1].count;
            r_pa[k].dsel   <= r_pa[k-1].dsel;
            r_pa[k].cmd    <= r_pa[k-1].cmd;
            r_pa[k].chunk  <= r_pa[k-1].chunk;
            r_a_rem[k]     <= n_a_rem[k];
            r_a_dq[k]      <= n_a_dq[k];
            r_c_rem[k]     <= n_c_rem[k];
            r_c_dq[k]      <= n_c_dq[k];
        end

        // Hand over: round the burst count up, pick the last burst size
        r_pb[0].status <= r_pa[NA].status;
        r_pb[0].count  <= r_pa[NA].count;
        r_pb[0].dsel   <= r_pa[NA].dsel;
        r_pb[0].cmd    <= r_pa[NA].cmd;
        r_pb[0].chunk  <= r_pa[NA].chunk;
        r_b_rem[0]     <= 5'd0;
        r_b_dq[0]      <= r_a_dq[NA];
        r_b_sec[0]     <= r_a_rem[NA] + 8'd1;
        r_b_nch[0]     <= r_c_dq[NA] + {8'd0, (r_c_rem[NA] != 8'd0)};
        r_b_last[0]    <= (r_c_rem[NA] != 8'd0) ? r_c_rem[NA] : r_pa[NA].chunk;
        for (int k = 1; k <= NB; k++) begin
            r_pb[k].status <= r_pb[k-1].status;
            r_pb[k].count  <= r_pb[k-1].count;
            r_pb[k].dsel   <= r_pb[k-1].dsel;
            r_pb[k].cmd    <= r_pb[k-1].cmd;
            r_pb[k].chunk  <= r_pb[k-1].chunk;
            r_b_rem[k]     <= n_b_rem[k];
            r_b_dq[k]      <= n_b_dq[k];
            r_b_sec[k]     <= r_b_sec[k-1];
            r_b_nch[k]     <= r_b_nch[k-1];
            r_b_last[k]    <= r_b_last[k-1];
        end

        // Output register: a failed request shows its status and zeros elsewhere
        o_status <= r_pb[NB].status;
        if (r_pb[NB].status == ST_OK) begin
            o_count_byte         <= r_pb[NB].count[7:0];
            o_sector_number      <= r_b_sec[NB];
            o_cylinder_number    <= r_b_dq[NB][15:0];
            o_drive_head         <= DH_BASE | {3'd0, r_pb[NB].dsel, 4'd0}
                                    | {3'd0, r_b_rem[NB]};
            o_command_code       <= r_pb[NB].cmd;
            o_chunk_sectors      <= r_pb[NB].chunk;
            o_chunk_count        <= r_b_nch[NB];
            o_last_chunk_sectors <= r_b_last[NB];
        end else begin
            o_count_byte         <= 8'd0;
            o_sector_number      <= 8'd0;
            o_cylinder_number    <= 16'd0;
            o_drive_head         <= 8'd0;
            o_command_code       <= 8'd0;
            o_chunk_sectors      <= 8'd0;
            o_chunk_count        <= 9'd0;
            o_last_chunk_sectors <= 8'd0;
        end
    end

endmodule

>>> bench/ata_request_chs_task_file_test.sv
// Self-checking testbench for the ATA CHS task-file builder.
module ata_request_chs_task_file_test;
    import atachs_pkg::*;

    // One disk request as presented on the request ports.
    typedef struct packed {
        logic        action;
        logic        dsel;
        logic [31:0] block;
        logic [8:0]  count;
    } t_disk_req;

    // One task-file result as seen on the result ports.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  count_byte;
        logic [7:0]  sector;
        logic [15:0] cyl;
        logic [7:0]  drive_head;
        logic [7:0]  cmd;
        logic [7:0]  chunk;
        logic [8:0]  nchunks;
        logic [7:0]  last;
    } t_task_file;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_action;
    logic        i_drive_select;
    logic [31:0] i_block_number;
    logic [8:0]  i_sector_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_result_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_count_byte;
    logic [7:0]  o_sector_number;
    logic [15:0] o_cylinder_number;
    logic [7:0]  o_drive_head;
    logic [7:0]  o_command_code;
    logic [7:0]  o_chunk_sectors;
    logic [8:0]  o_chunk_count;
    logic [7:0]  o_last_chunk_sectors;

    ata_request_chs_task_file DUT (.*);

    // Shadow copy of the geometry and partition registers.
    logic        sh_enabled;
    logic [7:0]  sh_spt;
    logic [4:0]  sh_heads;
    logic        sh_part_en;
    logic [31:0] sh_part_base;
    logic [31:0] sh_part_size;
    logic [7:0]  sh_multi;

    t_disk_req  pending_reqs[$];
    t_task_file expected_task_files[$];
    int         mismatches = 0;
    bit         stim_done = 0;
    bit         quiet_run = 0;   // long stretch with no gaps
    int         drive_cycle = 0;

    // Configuration write channel, driven by the initial block.
    logic        cfg_req = 0;
    logic [2:0]  cfg_idx_req;
    logic [31:0] cfg_data_req;
    bit          cfg_done;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Build the expected task file from the shadow registers.
    function automatic t_task_file build_task_file(t_disk_req r);
        t_task_file t;
        logic [31:0] cnt, abs_sec, track, hd, chunk, nch;
        t = '0;
        if (!sh_enabled || sh_heads == 0 || sh_spt == 0) begin
            t.status = ST_ABSENT;
            return t;
        end
        if (!sh_part_en || sh_part_size < r.block) begin
            t.status = ST_PARTBAD;
            return t;
        end
        cnt = (r.count == 0) ? 32'd2 : 32'(r.count);
        if (cnt > 256) cnt = 256;
        abs_sec = r.block + sh_part_base;
        track = abs_sec / sh_spt;
        hd = track % sh_heads;
        chunk = (sh_multi != 0) ? 32'(sh_multi) : 32'd1;
        nch = (cnt + chunk - 1) / chunk;
        t.status = ST_OK;
        t.count_byte = cnt[7:0];
        t.sector = 8'((abs_sec % sh_spt) + 1);
        t.cyl = 16'(track / sh_heads);
        t.drive_head = DH_BASE | {3'b0, r.dsel, 4'b0} | hd[7:0];
        if (r.action == 1'b0) t.cmd = (sh_multi != 0) ? OP_READM : OP_READ;
        else t.cmd = (sh_multi != 0) ? OP_WRITEM : OP_WRITE;
        t.chunk = chunk[7:0];
        t.nchunks = nch[8:0];
        t.last = 8'(cnt - (nch - 1) * chunk);
        return t;
    endfunction

    // Driver: hold start and payload until transfer, idle about 27 in 100.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drive_cycle <= drive_cycle + 1;
            if (!start || !busy) begin
                if (pending_reqs.size() != 0 &&
                    (quiet_run || $urandom_range(99) >= 27)) begin
                    t_disk_req r;
                    r = pending_reqs.pop_front();
                    expected_task_files.push_back(build_task_file(r));
                    start <= 1'b1;
                    i_action <= r.action;
                    i_drive_select <= r.dsel;
                    i_block_number <= r.block;
                    i_sector_count <= r.count;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Configuration channel: hold valid until the transfer completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            i_cfg_valid <= 1'b0;
            cfg_done <= 1'b1;
        end else if (cfg_req && !cfg_done && !i_cfg_valid) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfg_idx_req;
            i_cfg_data <= cfg_data_req;
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            t_task_file got, want;
            got = '{o_status, o_count_byte, o_sector_number, o_cylinder_number,
                    o_drive_head, o_command_code, o_chunk_sectors,
                    o_chunk_count, o_last_chunk_sectors};
            if (expected_task_files.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_task_files.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_idx_req <= idx;
        cfg_data_req <= val;
        cfg_done <= 1'b0;
        cfg_req <= 1'b1;
        @(posedge i_clk);
        while (!cfg_done) @(posedge i_clk);
        cfg_req <= 1'b0;
        case (idx)
            REG_ENABLED:   sh_enabled = val[0];
            REG_SPT:       sh_spt = val[7:0];
            REG_HEADS:     sh_heads = val[4:0];
            REG_PART_EN:   sh_part_en = val[0];
            REG_PART_BASE: sh_part_base = val;
            REG_PART_SIZE: sh_part_size = val;
            REG_MULTI:     sh_multi = val[7:0];
            default: ;
        endcase
    endtask

    // Wait for the pipeline to drain, then let the latency pass.
    task automatic drain_pipeline();
        while (pending_reqs.size() != 0 || start || expected_task_files.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_block();
        case ($urandom_range(4))
            0: return sh_part_size;
            1: return sh_part_size + 1;
            2: return $urandom_range(sh_part_size > 1000 ? 1000 : sh_part_size);
            3: return $urandom;
            default: return sh_part_size - $urandom_range(3);
        endcase
    endfunction

    function automatic t_disk_req rand_req();
        t_disk_req r;
        r.action = 1'($urandom_range(1));
        r.dsel = 1'($urandom_range(1));
        r.block = pick_block();
        case ($urandom_range(5))
            0: r.count = 9'd0;
            1: r.count = 9'(511 - $urandom_range(255));
            2: r.count = 9'd256;
            default: r.count = 9'($urandom_range(300));
        endcase
        return r;
    endfunction

    initial begin
        t_disk_req r;
        int multi_sizes[3] = '{1, 7, 255};
        sh_enabled = 0; sh_spt = 17; sh_heads = 0; sh_part_en = 0;
        sh_part_base = 0; sh_part_size = 0; sh_multi = 0;
        i_rst_n = 1'b0; start = 1'b0; i_action = 0; i_drive_select = 0;
        i_block_number = 0; i_sector_count = 0;
        i_cfg_valid = 0; i_cfg_index = REG_ENABLED; i_cfg_data = 0;
        cfg_idx_req = REG_ENABLED; cfg_data_req = 0; cfg_done = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: every request reports the controller absent.
        pending_reqs.push_back('{1'b0, 1'b0, 32'd0, 9'd1});
        pending_reqs.push_back('{1'b1, 1'b1, 32'hFFFF_FFFF, 9'h1FF});
        drain_pipeline();

        // Enabled but no heads, then zero sectors per track.
        write_reg(REG_ENABLED, 1);
        pending_reqs.push_back('{1'b0, 1'b0, 32'd5, 9'd3});
        drain_pipeline();
        write_reg(REG_HEADS, 16);
        write_reg(REG_SPT, 0);
        pending_reqs.push_back('{1'b1, 1'b0, 32'd5, 9'd3});
        drain_pipeline();
        // Partition disabled, then bounds checks and extremes.
        write_reg(REG_SPT, 63);
        pending_reqs.push_back('{1'b0, 1'b1, 32'd0, 9'd0});
        drain_pipeline();
        write_reg(REG_PART_EN, 1);
        write_reg(REG_PART_SIZE, 1000);
        write_reg(REG_PART_BASE, 32'hFFFF_FFF0);
        pending_reqs.push_back('{1'b0, 1'b0, 32'd1000, 9'd0});
        pending_reqs.push_back('{1'b1, 1'b1, 32'd1001, 9'd1});
        pending_reqs.push_back('{1'b0, 1'b1, 32'd0, 9'd256});
        pending_reqs.push_back('{1'b1, 1'b0, 32'd100, 9'h1FF});
        pending_reqs.push_back('{1'b0, 1'b0, 32'd20, 9'd257});
        drain_pipeline();
        // Multiple-sector bursts of one, odd and largest sizes.
        foreach (multi_sizes[k]) begin
            write_reg(REG_MULTI, 32'(multi_sizes[k]));
            pending_reqs.push_back('{1'b0, 1'b0, 32'd3, 9'd256});
            pending_reqs.push_back('{1'b1, 1'b1, 32'd999, 9'd15});
            pending_reqs.push_back('{1'b1, 1'b0, 32'd7, 9'd0});
            drain_pipeline();
        end
        // Head count above sixteen, largest geometry and sizes.
        write_reg(REG_HEADS, 31);
        write_reg(REG_SPT, 255);
        write_reg(REG_PART_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_PART_BASE, 0);
        pending_reqs.push_back('{1'b0, 1'b1, 32'hFFFF_FFFF, 9'd1});
        pending_reqs.push_back('{1'b1, 1'b0, 32'h8000_0000, 9'd100});
        drain_pipeline();

        // Random phases over many settings.
        for (int ph = 0; ph < 34; ph++) begin
            quiet_run = (ph == 10 || ph == 11);
            write_reg(REG_ENABLED, $urandom_range(15) != 0);
            write_reg(REG_SPT, $urandom_range(3) == 0 ? $urandom_range(1) * 255
                                                     : $urandom_range(255));
            write_reg(REG_HEADS, $urandom_range(3) == 0 ? 31 : $urandom_range(16));
            write_reg(REG_PART_EN, $urandom_range(9) != 0);
            write_reg(REG_PART_BASE, $urandom_range(1) ? $urandom : $urandom_range(5000));
            write_reg(REG_PART_SIZE, $urandom_range(2) == 0 ? $urandom
                                     : $urandom_range(1) ? 32'hFFFF_FFFF : 0);
            write_reg(REG_MULTI, $urandom_range(2) == 0 ? 0 : $urandom_range(255));
            for (int n = 0; n < 50; n++) begin
                r = rand_req();
                pending_reqs.push_back(r);
            end
            drain_pipeline();
        end
        stim_done = 1;
        if (mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
